// File: rtl/m68kea_pkg.sv
// m68kea_pkg: request/result beat types, access and mode codes, and
// sign-extension helpers for the effective address unit.
// No dependencies.
package m68kea_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  localparam logic [2:0] EAM_DREG   = 3'd0;
  localparam logic [2:0] EAM_AREG   = 3'd1;
  localparam logic [2:0] EAM_IND    = 3'd2;
  localparam logic [2:0] EAM_POSTIN = 3'd3;
  localparam logic [2:0] EAM_PREDEC = 3'd4;
  localparam logic [2:0] EAM_DISP   = 3'd5;
  localparam logic [2:0] EAM_INDEX  = 3'd6;
  localparam logic [2:0] EAM_EXT    = 3'd7;

  localparam logic [2:0] SUB_ABSW   = 3'd0;
  localparam logic [2:0] SUB_ABSL   = 3'd1;
  localparam logic [2:0] SUB_PCDISP = 3'd2;
  localparam logic [2:0] SUB_PCIDX  = 3'd3;
  localparam logic [2:0] SUB_IMM    = 3'd4;

  localparam logic [2:0] SP_REG     = 3'd7;

  localparam logic [1:0] BD_WORD    = 2'd2;
  localparam logic [1:0] BD_LONG    = 2'd3;

  localparam logic [1:0] SYNC_NONE  = 2'd0;
  localparam logic [1:0] SYNC_SUPER = 2'd1;
  localparam logic [1:0] SYNC_USER  = 2'd2;

  localparam logic [0:0] REG_FULL_EXT = 1'd0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  ea_mode;
    logic [2:0]  reg_num;
    logic [2:0]  size_bytes;
    logic [31:0] base_value;
    logic [31:0] pc_value;
    logic [31:0] index_value;
    logic [47:0] ext_stream;
    logic        supervisor;
  } ea_req_t;

  typedef struct packed {
    logic [31:0] address;
    logic        is_memory;
    logic        unimplemented;
    logic [31:0] an_new;
    logic        an_write;
    logic [1:0]  stack_sync;
    logic [1:0]  words_used;
    logic [4:0]  extra_cycles;
    logic        write_adjust;
  } ea_res_t;

  // indexed-mode unit result
  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  words;
    logic        unimpl;
  } idx_res_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    sx8 = {{24{v[7]}}, v};
  endfunction

endpackage

// File: rtl/m68kea_idx.sv
// m68kea_idx: brief and full-format indexed address (An or PC base).
// Depends on m68kea_pkg.
module m68kea_idx (
  input  logic                    full_ext_enable,
  input  logic [31:0]             base,
  input  logic [31:0]             idx,
  input  logic [47:0]             ext_stream,
  output m68kea_pkg::idx_res_t    res
);
  import m68kea_pkg::*;

  logic [15:0] w0, w1, w2;
  logic [1:0]  scale;
  logic [31:0] iv, iv_sh, bd, op_a, op_b, op_c;
  logic        full;
  logic [1:0]  bd_words;

  assign w0 = ext_stream[47:32];
  assign w1 = ext_stream[31:16];
  assign w2 = ext_stream[15:0];
  assign scale = w0[10:9];
  assign iv = w0[11] ? idx : sx16(idx[15:0]);
  assign iv_sh = iv << scale;
  assign full = w0[8] && full_ext_enable;

  always_comb begin
    case (w0[5:4])
      BD_WORD: begin
        bd = sx16(w1);
        bd_words = 2'd2;
      end
      BD_LONG: begin
        bd = {w1, w2};
        bd_words = 2'd3;
      end
      default: begin
        bd = '0;
        bd_words = 2'd1;
      end
    endcase
  end

  always_comb begin
    if (full) begin
      op_a = w0[7] ? '0 : base;
      op_b = bd;
      op_c = w0[6] ? '0 : iv_sh;
      res.words = bd_words;
      res.unimpl = (w0[1:0] != 2'd0);
    end else begin
      op_a = base;
      op_b = sx8(w0[7:0]);
      op_c = full_ext_enable ? iv_sh : iv;
      res.words = 2'd1;
      res.unimpl = 1'b0;
    end
    res.address = res.unimpl ? '0 : (op_a + op_b + op_c);
  end

endmodule

// File: rtl/m68kea_core.sv
// m68kea_core: mode decode, address select, An update and cycle count.
// Depends on m68kea_pkg and m68kea_idx.
module m68kea_core (
  input  logic                 full_ext_enable,
  input  m68kea_pkg::ea_req_t  req,
  output m68kea_pkg::ea_res_t  res
);
  import m68kea_pkg::*;

  kind_t       kind;
  logic [2:0]  sz, step;
  logic        is_rd, is_st, sz_short;
  logic [15:0] w0, w1;
  logic [31:0] an, idx_base;
  idx_res_t    ix;
  logic [31:0] addr, an_nv;
  logic        mem, unimpl, wr, adj;
  logic [1:0]  words;
  logic [4:0]  cyc;

  assign an = req.base_value;
  assign w0 = req.ext_stream[47:32];
  assign w1 = req.ext_stream[31:16];

  always_comb begin
    kind = kind_t'(req.mode);
    if (kind == KIND_RSVD) begin
      kind = KIND_READ;
    end
    case (req.size_bytes)
      3'd1:    sz = 3'd1;
      3'd2:    sz = 3'd2;
      default: sz = 3'd4;
    endcase
    if (kind == KIND_ADDR) begin
      sz = 3'd4;
    end
  end

  assign is_rd = (kind == KIND_READ);
  assign is_st = (kind == KIND_STORE);
  assign sz_short = (sz != 3'd4);
  assign step = (req.reg_num == SP_REG && sz == 3'd1) ? 3'd2 : sz;
  assign idx_base = (req.ea_mode == EAM_EXT) ? req.pc_value : an;

  m68kea_idx u_idx (
    .full_ext_enable (full_ext_enable),
    .base            (idx_base),
    .idx             (req.index_value),
    .ext_stream      (req.ext_stream),
    .res             (ix)
  );

  always_comb begin
    addr = '0;
    mem = 1'b0;
    unimpl = 1'b0;
    an_nv = '0;
    wr = 1'b0;
    words = 2'd0;
    cyc = 5'd0;
    adj = 1'b0;
    if (is_st && req.ea_mode == EAM_POSTIN) begin
      addr = an;
      mem = 1'b1;
      an_nv = an + 32'(step);
      wr = 1'b1;
    end else if (is_st && req.ea_mode == EAM_PREDEC && !sz_short) begin
      // two word steps; the second only when the first lands even
      cyc = 5'd4;
      adj = 1'b1;
      an_nv = an[0] ? (an - 32'd2) : (an - 32'd4);
      addr = an_nv;
      mem = 1'b1;
      wr = 1'b1;
    end else begin
      if (is_st && req.ea_mode == EAM_PREDEC) begin
        cyc = 5'd2;
        adj = 1'b1;
      end
      case (req.ea_mode)
        EAM_IND: begin
          addr = an;
          mem = 1'b1;
        end
        EAM_POSTIN: begin
          addr = an;
          mem = 1'b1;
          an_nv = an + 32'(step);
          wr = 1'b1;
        end
        EAM_PREDEC: begin
          cyc = cyc + 5'd2;
          an_nv = an - 32'(step);
          wr = 1'b1;
          addr = an_nv;
          mem = 1'b1;
        end
        EAM_DISP: begin
          cyc = cyc + 5'd4;
          words = 2'd1;
          addr = an + sx16(w0);
          mem = 1'b1;
        end
        EAM_INDEX: begin
          cyc = cyc + 5'd6;
          addr = ix.address;
          words = ix.words;
          unimpl = ix.unimpl;
          mem = !ix.unimpl;
        end
        EAM_EXT: begin
          case (req.reg_num)
            SUB_ABSW: begin
              cyc = cyc + 5'd4;
              words = 2'd1;
              addr = sx16(w0);
              mem = 1'b1;
            end
            SUB_ABSL: begin
              cyc = cyc + 5'd8;
              words = 2'd2;
              addr = {w0, w1};
              mem = 1'b1;
            end
            SUB_PCDISP: begin
              cyc = cyc + 5'd4;
              words = 2'd1;
              addr = req.pc_value + sx16(w0);
              mem = 1'b1;
            end
            SUB_PCIDX: begin
              cyc = cyc + 5'd6;
              addr = ix.address;
              words = ix.words;
              unimpl = ix.unimpl;
              mem = !ix.unimpl;
            end
            SUB_IMM: begin
              if (is_rd) begin
                cyc = cyc + (sz_short ? 5'd4 : 5'd8);
                words = sz_short ? 2'd1 : 2'd2;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (is_rd && mem) begin
        cyc = cyc + (sz_short ? 5'd4 : 5'd8);
      end
    end
  end

  always_comb begin
    res.address = addr;
    res.is_memory = mem;
    res.unimplemented = unimpl;
    res.an_new = wr ? an_nv : '0;
    res.an_write = wr;
    res.stack_sync = (wr && req.reg_num == SP_REG) ?
                     (req.supervisor ? SYNC_SUPER : SYNC_USER) : SYNC_NONE;
    res.words_used = words;
    res.extra_cycles = cyc;
    res.write_adjust = adj;
  end

endmodule

// File: rtl/m68k_effective_address_unit.sv
// m68k_effective_address_unit: top level with request register, config
// register port and result register. Depends on m68kea_pkg, m68kea_core.
//
// Usage:
//   Request channel: drive req and pulse start; a beat is taken at any edge
//   with start high and busy low. busy is high only during reset, so one
//   request can be issued every cycle.
//   Result channel: done strobes for one cycle with res; each beat passes
//   through the request register, then the result register. Throughput
//   is one beat per cycle, set by the single pass through the decode,
//   indexed adder and An update logic.
//   The receiver cannot stall; every result must be captured on its strobe.
//   Config: APB register 0 (byte address 0), bit 0 = full_ext_enable.
//   Writes complete in the access cycle, pready is tied high. Write it only
//   while no request is in flight.
//   Reset (rst, synchronous) clears full_ext_enable and drops any beat in
//   flight; no result is produced for requests taken before reset.
module m68k_effective_address_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  m68kea_pkg::ea_req_t  req,
  output logic                 done,
  output m68kea_pkg::ea_res_t  res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import m68kea_pkg::*;

  logic    full_ext_enable;
  logic    req_valid;
  ea_req_t req_q;
  ea_res_t res_c;
  logic    sel_fe;

  assign busy = rst;
  assign pready = 1'b1;
  assign sel_fe = (paddr[2] == REG_FULL_EXT);
  assign prdata = sel_fe ? {31'd0, full_ext_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_ext_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_fe) begin
      full_ext_enable <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      req_valid <= start && !busy;
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    res <= res_c;
  end

  m68kea_core u_core (
    .full_ext_enable (full_ext_enable),
    .req             (req_q),
    .res             (res_c)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result beat missing two cycles after request");

  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.is_memory && res.unimplemented))
    else $error("unimplemented form flagged as memory operand");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    done && !res.is_memory |-> res.address == 32'd0)
    else $error("non-memory result carries an address");

  a_an_zero: assert property (@(posedge clk) disable iff (rst)
    done && !res.an_write |-> (res.an_new == 32'd0 && res.stack_sync == SYNC_NONE))
    else $error("An update fields set without a write");

  a_adj_wr: assert property (@(posedge clk) disable iff (rst)
    done && res.write_adjust |-> res.an_write && res.is_memory)
    else $error("bus adjust without predecrement");

endmodule
